>>> src/prsq_pkg.sv
package prsq_pkg;

  localparam int MaxThreads   = 64;
  localparam int PriorityBits = 6;
  localparam int IdBits       = 6;
  localparam int TickBits     = 63;
  localparam int CountBits    = $clog2(MaxThreads + 1);
  localparam int IdxBits      = $clog2(MaxThreads);

  localparam logic [7:0]          SliceReset = 8'd4;
  localparam logic [7:0]          SliceLimit = 8'd255;
  localparam logic [TickBits-1:0] TickMax    = {TickBits{1'b1}};

  typedef enum logic [1:0] {
    CMD_MAKE_READY = 2'd0,
    CMD_SLEEP      = 2'd1,
    CMD_TICK       = 2'd2,
    CMD_DISPATCH   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [IdBits-1:0]       id;
    logic [PriorityBits-1:0] prio;
  } entry_t;

  // Control from the sequencer to the ready-queue cells
  typedef struct packed {
    logic   ins;   // ordered insert of ent
    logic   pop;   // shift toward the head
    entry_t ent;
  } rq_ctrl_t;

  // Control to the sleep cells
  typedef struct packed {
    logic                ins;    // append at position cnt
    logic                step;   // one scan step: rotate and keep or drop head
    logic                keep;   // head is kept (written back at slot cnt)
    logic [CountBits-1:0] cnt;
    logic [TickBits-1:0] tick;
    entry_t              ent;
  } sl_ctrl_t;

endpackage

>>> src/prsq_ready_cell.sv
// One slot of the ordered ready queue. Insert: a cell takes the new entry
// when it is the first slot whose entry has lower priority (or is empty),
// and every later slot takes its left neighbor.
module prsq_ready_cell
  import prsq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  rq_ctrl_t ctrl_i,
  input  entry_t   left_i,
  input  logic     left_shift_i,   // a slot to the left has taken the insert
  input  logic     left_valid_i,
  input  entry_t   right_i,
  input  logic     right_valid_i,
  output entry_t   ent_o,
  output logic     valid_o,
  output logic     shift_o
);

  entry_t ent_q, ent_d;
  logic   valid_q, valid_d;
  logic   here;

  // Insert lands here if no earlier slot shifted and this slot loses
  assign here    = !left_shift_i && left_valid_i &&
                   (!valid_q || ent_q.prio < ctrl_i.ent.prio);
  assign shift_o = left_shift_i || here;

  always_comb begin
    ent_d   = ent_q;
    valid_d = valid_q;
    if (ctrl_i.ins) begin
      if (left_shift_i) begin
        ent_d   = left_i;
        valid_d = left_valid_i && valid_q ? 1'b1 : valid_q | left_valid_i;
      end else if (here) begin
        ent_d   = ctrl_i.ent;
        valid_d = 1'b1;
      end
    end else if (ctrl_i.pop) begin
      ent_d   = right_i;
      valid_d = right_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o   = ent_q;
  assign valid_o = valid_q;

endmodule

>>> src/prsq_sleep_cell.sv
// One slot of the sleep table. A scan step shifts the row one slot toward
// the head. A kept head entry is written back at the slot given by ctrl cnt,
// which is the slot that reaches the next packed position when the pass ends.
module prsq_sleep_cell
  import prsq_pkg::*;
(
  input  logic                clk_i,
  input  sl_ctrl_t            ctrl_i,
  input  logic [IdxBits-1:0]  pos_i,
  input  logic [TickBits-1:0] right_tick_i,
  input  entry_t              right_ent_i,
  input  logic [TickBits-1:0] head_tick_i,
  input  entry_t              head_ent_i,
  output logic [TickBits-1:0] tick_o,
  output entry_t              ent_o
);

  logic [TickBits-1:0] tick_q, tick_d;
  entry_t              ent_q, ent_d;

  always_comb begin
    tick_d = tick_q;
    ent_d  = ent_q;
    if (ctrl_i.ins && ctrl_i.cnt[IdxBits-1:0] == pos_i) begin
      tick_d = ctrl_i.tick;
      ent_d  = ctrl_i.ent;
    end else if (ctrl_i.step) begin
      if (ctrl_i.keep && ctrl_i.cnt[IdxBits-1:0] == pos_i) begin
        tick_d = head_tick_i;
        ent_d  = head_ent_i;
      end else begin
        tick_d = right_tick_i;
        ent_d  = right_ent_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tick_q <= tick_d;
    ent_q  <= ent_d;
  end

  assign tick_o = tick_q;
  assign ent_o  = ent_q;

endmodule

>>> src/priority_ready_and_sleep_queue.sv
// Thread scheduler with a priority-ordered ready queue and a sleep table,
// both held as rows of 64 cells. make_ready, sleep and dispatch are
// registered in ST_DONE before the output register takes the result; tick
// walks the whole sleep table, one sleeper per cycle through a full pass of
// the sleep row, whatever the number of sleepers. Woken sleepers enter the
// ready queue in sleep order, one per cycle during that walk, and the
// remaining sleepers end up packed at the front in their old order. A new
// request is taken once the previous result has moved into the output
// register.
module priority_ready_and_sleep_queue
  import prsq_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    time_slice_we_i,
  input  logic [7:0]              time_slice_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              cmd_i,
  input  logic [IdBits-1:0]       thread_id_i,
  input  logic [PriorityBits-1:0] priority_req_i,
  input  logic [TickBits-1:0]     tick_value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [IdBits-1:0]       dispatch_id_o,
  output logic                    dispatch_valid_o,
  output logic [TickBits-1:0]     next_wake_tick_o,
  output logic [CountBits-1:0]    woken_count_o,
  output logic                    preempt_o,
  output logic                    overflow_o
);

  state_e state_q, state_d;
  logic [7:0]           slice_cfg_q, slice_q, slice_d;
  logic [CountBits-1:0] rcnt_q, rcnt_d, scnt_q, scnt_d;
  logic [CountBits-1:0] keep_q, keep_d, woken_q, woken_d;
  logic [IdxBits-1:0]   step_q, step_d;
  logic [TickBits-1:0]  early_q, early_d, lo_q, lo_d, tv_q;
  logic                 ovf_q, ovf_d;
  logic                 dv_q, dv_d;
  logic [IdBits-1:0]    did_q, did_d;
  logic                 out_valid_q;
  logic                 out_load;
  cmd_e                 cmd;
  rq_ctrl_t             rq;
  sl_ctrl_t             sl;

  entry_t              r_ent   [MaxThreads];
  logic                r_valid [MaxThreads];
  logic                r_shift [MaxThreads];
  logic [TickBits-1:0] s_tick  [MaxThreads];
  entry_t              s_ent   [MaxThreads];

  assign cmd        = cmd_e'(cmd_i);
  assign in_ready_o = (state_q == ST_IDLE);

  // Ready-queue row
  for (genvar g = 0; g < MaxThreads; g++) begin : g_rq
    prsq_ready_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (rq),
      .left_i       ((g == 0) ? rq.ent : r_ent[(g == 0) ? 0 : g - 1]),
      .left_shift_i ((g == 0) ? 1'b0 : r_shift[(g == 0) ? 0 : g - 1]),
      .left_valid_i ((g == 0) ? 1'b1 : r_valid[(g == 0) ? 0 : g - 1]),
      .right_i      (r_ent[(g == MaxThreads - 1) ? g : g + 1]),
      .right_valid_i((g == MaxThreads - 1) ? 1'b0 : r_valid[(g == MaxThreads - 1) ? g : g + 1]),
      .ent_o        (r_ent[g]),
      .valid_o      (r_valid[g]),
      .shift_o      (r_shift[g])
    );
  end

  // Sleep row
  for (genvar g = 0; g < MaxThreads; g++) begin : g_sl
    prsq_sleep_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (sl),
      .pos_i       (IdxBits'(g)),
      .right_tick_i(s_tick[(g == MaxThreads - 1) ? g : g + 1]),
      .right_ent_i (s_ent[(g == MaxThreads - 1) ? g : g + 1]),
      .head_tick_i (s_tick[0]),
      .head_ent_i  (s_ent[0]),
      .tick_o      (s_tick[g]),
      .ent_o       (s_ent[g])
    );
  end

  // Sequencer
  logic in_tbl, due, full;
  always_comb begin
    state_d  = state_q;
    slice_d  = slice_q;
    rcnt_d   = rcnt_q;
    scnt_d   = scnt_q;
    keep_d   = keep_q;
    woken_d  = woken_q;
    step_d   = step_q;
    early_d  = early_q;
    lo_d     = lo_q;
    ovf_d    = ovf_q;
    dv_d     = dv_q;
    did_d    = did_q;
    out_load = 1'b0;
    rq       = '0;
    sl       = '0;
    sl.cnt   = scnt_q;
    sl.tick  = tick_value_i;
    sl.ent   = '{id: thread_id_i, prio: priority_req_i};
    in_tbl   = ({1'b0, step_q} < scnt_q);
    due      = in_tbl && (s_tick[0] <= tv_q);
    full     = (rcnt_q == CountBits'(MaxThreads));
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ovf_d   = 1'b0;
          dv_d    = 1'b0;
          did_d   = '0;
          woken_d = '0;
          case (cmd)
            CMD_MAKE_READY: begin
              rq.ent = '{id: thread_id_i, prio: priority_req_i};
              if (rcnt_q == CountBits'(MaxThreads)) begin
                ovf_d = 1'b1;
              end else begin
                rq.ins = 1'b1;
                rcnt_d = rcnt_q + 1'b1;
              end
              state_d = ST_DONE;
            end
            CMD_SLEEP: begin
              if (scnt_q == CountBits'(MaxThreads)) begin
                ovf_d = 1'b1;
              end else begin
                sl.ins = 1'b1;
                scnt_d = scnt_q + 1'b1;
                if (tick_value_i < early_q) early_d = tick_value_i;
              end
              state_d = ST_DONE;
            end
            CMD_TICK: begin
              keep_d  = '0;
              step_d  = '0;
              lo_d    = TickMax;
              if (slice_q != SliceLimit) slice_d = slice_q + 8'd1;
              state_d = ST_SCAN;
            end
            default: begin
              if (rcnt_q != '0) begin
                dv_d   = 1'b1;
                did_d  = r_ent[0].id;
                rq.pop = 1'b1;
                rcnt_d = rcnt_q - 1'b1;
              end
              slice_d = '0;
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Head slot holds the sleeper at scan position step_q; a kept one
        // goes to the slot that shifts down to position keep_q by the end
        sl.step = 1'b1;
        sl.keep = in_tbl && !due;
        sl.cnt  = keep_q + CountBits'(MaxThreads - 1) - {1'b0, step_q};
        rq.ent  = s_ent[0];
        if (due) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            rq.ins  = 1'b1;
            rcnt_d  = rcnt_q + 1'b1;
            woken_d = woken_q + 1'b1;
          end
        end else if (in_tbl) begin
          keep_d = keep_q + 1'b1;
          if (s_tick[0] < lo_q) lo_d = s_tick[0];
        end
        step_d = step_q + 1'b1;
        if (step_q == IdxBits'(MaxThreads - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // At the end of a scan the kept sleepers fill the front slots in order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slice_cfg_q <= SliceReset;
      slice_q     <= '0;
      rcnt_q      <= '0;
      scnt_q      <= '0;
      early_q     <= TickMax;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (time_slice_we_i) slice_cfg_q <= time_slice_i;
      slice_q <= slice_d;
      rcnt_q  <= rcnt_d;
      if (state_q == ST_SCAN && state_d == ST_DONE) begin
        scnt_q  <= keep_d;
        early_q <= lo_d;
      end else begin
        scnt_q  <= scnt_d;
        early_q <= early_d;
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    keep_q  <= keep_d;
    woken_q <= woken_d;
    step_q  <= step_d;
    lo_q    <= lo_d;
    ovf_q   <= ovf_d;
    dv_q    <= dv_d;
    did_q   <= did_d;
    if (state_q == ST_IDLE && in_valid_i) tv_q <= tick_value_i;
    if (out_load) begin
      dispatch_id_o    <= did_q;
      dispatch_valid_o <= dv_q;
      next_wake_tick_o <= early_q;
      woken_count_o    <= woken_q;
      preempt_o        <= (slice_q >= slice_cfg_q);
      overflow_o       <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import prsq_pkg::*;

  typedef struct {
    logic [IdBits-1:0]    id;
    logic                 dv;
    logic [TickBits-1:0]  wake;
    logic [CountBits-1:0] woken;
    logic                 preempt;
    logic                 ovf;
  } sched_result_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    time_slice_we_i;
  logic [7:0]              time_slice_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [1:0]              cmd_i;
  logic [IdBits-1:0]       thread_id_i;
  logic [PriorityBits-1:0] priority_req_i;
  logic [TickBits-1:0]     tick_value_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [IdBits-1:0]       dispatch_id_o;
  logic                    dispatch_valid_o;
  logic [TickBits-1:0]     next_wake_tick_o;
  logic [CountBits-1:0]    woken_count_o;
  logic                    preempt_o;
  logic                    overflow_o;

  priority_ready_and_sleep_queue u_top (
    .clk_i, .rst_ni, .time_slice_we_i, .time_slice_i, .in_valid_i, .in_ready_o,
    .cmd_i, .thread_id_i, .priority_req_i, .tick_value_i, .out_valid_o,
    .out_ready_i, .dispatch_id_o, .dispatch_valid_o, .next_wake_tick_o,
    .woken_count_o, .preempt_o, .overflow_o
  );

  // Scheduler shadow state
  entry_t              rdy_q[$];
  entry_t              slp_tag[$];
  logic [TickBits-1:0] slp_wake[$];
  logic [TickBits-1:0] earliest;
  logic [7:0]          slice_cnt;
  logic [7:0]          slice_cfg;
  sched_result_t       pending_results[$];

  int  errors;
  int  n_results;
  int  n_req;
  int  n_ovf;
  int  n_woken;
  longint cycles;
  logic   [TickBits-1:0] now;

  initial begin
    clk_i = 1'b0;
    forever begin
      #6 clk_i = 1'b1;
      #6 clk_i = 1'b0;
    end
  end

  // Mostly short gaps, some long
  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  function automatic bit ready_push(entry_t e);
    int pos;
    if (rdy_q.size() >= MaxThreads) return 1'b0;
    pos = 0;
    while (pos < rdy_q.size() && rdy_q[pos].prio >= e.prio) pos++;
    rdy_q.insert(pos, e);
    return 1'b1;
  endfunction

  // Compute the expected result of one request and update the shadow state
  function automatic sched_result_t schedule_step(cmd_e c, entry_t e,
                                                  logic [TickBits-1:0] tv);
    sched_result_t r;
    entry_t kt[$];
    logic [TickBits-1:0] kw[$];
    logic [TickBits-1:0] lo;
    r.id = '0; r.dv = 1'b0; r.woken = '0; r.ovf = 1'b0;
    case (c)
      CMD_MAKE_READY: begin
        if (!ready_push(e)) r.ovf = 1'b1;
      end
      CMD_SLEEP: begin
        if (slp_tag.size() >= MaxThreads) begin
          r.ovf = 1'b1;
        end else begin
          slp_tag.push_back(e);
          slp_wake.push_back(tv);
          if (tv < earliest) earliest = tv;
        end
      end
      CMD_TICK: begin
        lo = TickMax;
        foreach (slp_tag[i]) begin
          if (slp_wake[i] <= tv) begin
            if (ready_push(slp_tag[i])) r.woken++;
            else r.ovf = 1'b1;
          end else begin
            kt.push_back(slp_tag[i]);
            kw.push_back(slp_wake[i]);
            if (slp_wake[i] < lo) lo = slp_wake[i];
          end
        end
        slp_tag = kt;
        slp_wake = kw;
        earliest = lo;
        if (slice_cnt != SliceLimit) slice_cnt++;
      end
      default: begin
        if (rdy_q.size() > 0) begin
          r.id = rdy_q[0].id;
          r.dv = 1'b1;
          void'(rdy_q.pop_front());
        end
        slice_cnt = '0;
      end
    endcase
    r.wake = earliest;
    r.preempt = (slice_cnt >= slice_cfg);
    return r;
  endfunction

  // Send one request and queue its expected result
  task automatic send_req(cmd_e c, logic [IdBits-1:0] id,
                          logic [PriorityBits-1:0] pr, logic [TickBits-1:0] tv);
    entry_t e;
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    e.id = id;
    e.prio = pr;
    in_valid_i     <= 1'b1;
    cmd_i          <= c;
    thread_id_i    <= id;
    priority_req_i <= pr;
    tick_value_i   <= tv;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(schedule_step(c, e, tv));
    if (c == CMD_SLEEP || c == CMD_MAKE_READY) n_req++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic set_slice(logic [7:0] v);
    drain();
    time_slice_we_i <= 1'b1;
    time_slice_i    <= v;
    @(posedge clk_i);
    time_slice_we_i <= 1'b0;
    slice_cfg = v;
  endtask

  // Check process: result receiver with random stalls
  initial begin
    sched_result_t x;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result", $time);
        end else begin
          x = pending_results.pop_front();
          if (overflow_o) n_ovf++;
          n_woken += woken_count_o;
          if (dispatch_id_o !== x.id) begin
            errors++;
            $display("%0t: dispatch_id exp %0d got %0d", $time, x.id, dispatch_id_o);
          end
          if (dispatch_valid_o !== x.dv) begin
            errors++;
            $display("%0t: dispatch_valid exp %0b got %0b", $time, x.dv,
                     dispatch_valid_o);
          end
          if (next_wake_tick_o !== x.wake) begin
            errors++;
            $display("%0t: next_wake_tick exp %0h got %0h", $time, x.wake,
                     next_wake_tick_o);
          end
          if (woken_count_o !== x.woken) begin
            errors++;
            $display("%0t: woken_count exp %0d got %0d", $time, x.woken,
                     woken_count_o);
          end
          if (preempt_o !== x.preempt) begin
            errors++;
            $display("%0t: preempt exp %0b got %0b", $time, x.preempt, preempt_o);
          end
          if (overflow_o !== x.ovf) begin
            errors++;
            $display("%0t: overflow exp %0b got %0b", $time, x.ovf, overflow_o);
          end
        end
      end
      out_ready_i <= ($urandom_range(0, 4) != 0) || (cycles % 2000 < 300);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 1500000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Directed: extremes, every command, idle dispatch, past wake tick
  task automatic test_directed();
    send_req(CMD_DISPATCH, '0, '0, '0);
    send_req(CMD_TICK, '0, '0, '0);
    send_req(CMD_MAKE_READY, 6'd63, 6'd0, TickMax);
    send_req(CMD_MAKE_READY, 6'd0, 6'd63, '0);
    send_req(CMD_MAKE_READY, 6'd21, 6'd63, '0);
    send_req(CMD_SLEEP, 6'd42, 6'd42, TickMax);
    send_req(CMD_SLEEP, 6'd5, 6'd10, 63'd100);
    send_req(CMD_SLEEP, 6'd6, 6'd10, 63'd0);
    send_req(CMD_TICK, '0, '0, 63'd50);
    send_req(CMD_TICK, 6'h3f, 6'h3f, 63'd100);
    repeat (5) send_req(CMD_TICK, '0, '0, 63'd100);
    repeat (7) send_req(CMD_DISPATCH, 6'h2a, 6'h15, 63'h2aaa_aaaa_aaaa_aaaa);
    send_req(CMD_TICK, '0, '0, TickMax);
    send_req(CMD_DISPATCH, '0, '0, '0);
  endtask

  // Fill both tables past capacity, wake some into the full queue, drain it, wake the rest
  task automatic test_overflow();
    for (int i = 0; i < MaxThreads + 2; i++)
      send_req(CMD_MAKE_READY, i[5:0], 6'($urandom_range(0, 3)), '0);
    for (int i = 0; i < MaxThreads + 2; i++)
      send_req(CMD_SLEEP, i[5:0], 6'($urandom), 63'($urandom_range(1, 20)));
    send_req(CMD_TICK, '0, '0, 63'd10);
    for (int i = 0; i < MaxThreads + 1; i++)
      send_req(CMD_DISPATCH, '0, '0, '0);
    send_req(CMD_TICK, '0, '0, TickMax);
    while (rdy_q.size() > 0) send_req(CMD_DISPATCH, '0, '0, '0);
  endtask

  // Random mix around a moving clock
  task automatic test_random(int n);
    int k;
    logic [TickBits-1:0] tv;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      if ($urandom_range(0, 19) == 0) tv = 63'({$urandom, $urandom});
      else tv = now + 63'($urandom_range(0, 30));
      if (k < 3)
        send_req(CMD_MAKE_READY, 6'($urandom), 6'($urandom),
                 63'({$urandom, $urandom}));
      else if (k < 6)
        send_req(CMD_SLEEP, 6'($urandom), 6'($urandom), tv);
      else if (k < 8) begin
        if ($urandom_range(0, 9) != 0) now = now + 63'($urandom_range(0, 10));
        else now = 63'({$urandom, $urandom});
        send_req(CMD_TICK, 6'($urandom), 6'($urandom), now);
      end else
        send_req(CMD_DISPATCH, 6'($urandom), 6'($urandom),
                 63'({$urandom, $urandom}));
    end
  endtask

  initial begin
    errors = 0; n_results = 0; n_req = 0; n_ovf = 0; n_woken = 0; cycles = 0;
    now = '0;
    earliest = TickMax;
    slice_cnt = '0;
    slice_cfg = SliceReset;
    rst_ni          = 1'b0;
    time_slice_we_i = 1'b0;
    time_slice_i    = '0;
    in_valid_i      = 1'b0;
    cmd_i           = '0;
    thread_id_i     = '0;
    priority_req_i  = '0;
    tick_value_i    = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    set_slice(8'd1);
    test_overflow();
    set_slice(8'd255);
    test_random(60);
    set_slice(8'd0);
    test_random(30);
    set_slice(8'($urandom_range(2, 6)));
    test_random(60);
    set_slice(8'd3);
    test_random(50);
    drain();

    $display("Covered %0d results, %0d inserts, %0d woken, %0d overflows", n_results,
             n_req, n_woken, n_ovf);
    $display("Time slice settings 4, 1, 255, 0 and mid values exercised");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
